// ----- sv/bbum_pkg.sv -----
// Shared types, constants and helpers of the box blur unsharp mask block.
package bbum_pkg;

    // Pixel layout: red in bits 7:0, green in 15:8, blue in 23:16.
    localparam int unsigned LANE_W    = 8;
    localparam int unsigned NUM_LANES = 3;
    localparam int unsigned PIX_W     = LANE_W * NUM_LANES;

    // Frame geometry.
    localparam int unsigned MAX_WIDTH_DEF = 1024;
    localparam int unsigned MAX_HEIGHT    = 4096;
    localparam int unsigned ROW_W         = 12;
    localparam int unsigned WIDTH_REG_W   = 11;
    localparam int unsigned HEIGHT_REG_W  = 13;
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

    // Configuration port.
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned REG_SEL_BIT = 2;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [0:0] {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    // Blur arithmetic: floor(sum / 9) as (sum * 7282) >> 16, exact for sums below 4096.
    localparam int unsigned SUM_W       = 12;
    localparam int unsigned RECIP_W     = 13;
    localparam int unsigned RECIP_SHIFT = 16;
    localparam int unsigned PROD_W      = SUM_W + RECIP_W;
    localparam int unsigned SMOOTH_W    = PROD_W - RECIP_SHIFT;
    localparam int unsigned BOOST_W     = LANE_W + 2;
    localparam logic [RECIP_W-1:0] RECIP9   = 13'd7282;
    localparam logic [LANE_W-1:0]  LANE_MAX = 8'd255;

    // Job queue between front and back.
    localparam int unsigned JOBQ_DEPTH = 4;

    typedef logic [PIX_W-1:0] t_pixel;

    // Control part of one job handed from the front to the back.
    typedef struct packed {
        logic is_flush;  // drain beat taken from the line stores
        logic emit;      // data beat that produces a result
        logic interior;  // result pixel gets sharpened
        logic last;      // final result of the frame
        logic sel_mid;   // drain beat reads the middle store, else the upper one
    } t_job_ctl;

    function automatic logic [LANE_W-1:0] lane_of(input t_pixel px, input int unsigned k);
        return px[LANE_W*k +: LANE_W];
    endfunction

endpackage

// ----- sv/bbum_front.sv -----
// Front end: tracks raster positions, classifies each accepted beat and issues jobs.
module bbum_front #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_restart,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_w_last,
    input  logic [bbum_pkg::ROW_W-1:0]     i_h_last,
    input  logic                           i_accept,
    input  logic                           i_cmd,
    input  bbum_pkg::t_pixel               i_px,
    output logic                           o_push,
    output bbum_pkg::t_job_ctl             o_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_addr,
    output bbum_pkg::t_pixel               o_px
);
    import bbum_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WIDTH);

    logic [AW-1:0]    r_in_col, n_in_col;
    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic [AW-1:0]    r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;
    logic             r_tail, n_tail;

    logic             is_flush;
    logic             new_frame;
    logic [AW-1:0]    col;
    logic [ROW_W-1:0] row;
    logic [AW-1:0]    ocol;
    logic [ROW_W-1:0] orow;
    logic [AW-1:0]    adv_ocol;
    logic [ROW_W-1:0] adv_orow;
    logic             emit;
    logic             interior;
    logic             out_last;

    always_comb begin
        is_flush  = (i_cmd == CMD_FLUSH);
        // A pixel arriving while a tail is pending starts a new frame at (0,0).
        new_frame = r_tail && !is_flush;
        col       = new_frame ? '0 : r_in_col;
        row       = new_frame ? '0 : r_in_row;
        ocol      = new_frame ? '0 : r_out_col;
        orow      = new_frame ? '0 : r_out_row;

        if (ocol == i_w_last) begin
            adv_ocol = '0;
            adv_orow = orow + ROW_W'(1);
        end else begin
            adv_ocol = ocol + AW'(1);
            adv_orow = orow;
        end

        // Results start once a line plus one pixel has arrived.
        emit     = (row > ROW_W'(1)) || ((row == ROW_W'(1)) && (col != '0));
        interior = (orow != '0) && (orow < i_h_last) && (ocol != '0) && (ocol < i_w_last);
        out_last = (r_out_row == i_h_last) && (r_out_col == i_w_last);

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_tail    = r_tail;
        o_push    = 1'b0;
        o_ctl     = '0;
        o_addr    = col;
        o_px      = i_px;

        if (i_accept) begin
            if (is_flush) begin
                if (r_tail) begin
                    o_push        = 1'b1;
                    o_addr        = r_out_col;
                    o_ctl.is_flush = 1'b1;
                    o_ctl.emit    = 1'b1;
                    o_ctl.sel_mid = (r_out_row == i_h_last);
                    o_ctl.last    = out_last;
                    if (out_last) begin
                        n_out_col = '0;
                        n_out_row = '0;
                        n_tail    = 1'b0;
                    end else begin
                        n_out_col = adv_ocol;
                        n_out_row = adv_orow;
                    end
                end
            end else begin
                o_push         = 1'b1;
                o_ctl.emit     = emit;
                o_ctl.interior = interior;
                n_tail         = 1'b0;
                n_out_col      = emit ? adv_ocol : ocol;
                n_out_row      = emit ? adv_orow : orow;
                if (col == i_w_last) begin
                    n_in_col = '0;
                    if (row == i_h_last) begin
                        n_in_row = '0;
                        n_tail   = 1'b1;
                    end else begin
                        n_in_row = row + ROW_W'(1);
                    end
                end else begin
                    n_in_col = col + AW'(1);
                    n_in_row = row;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_tail    <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_tail    <= n_tail;
        end
    end

endmodule

// ----- sv/bbum_jobq.sv -----
// Short job queue that decouples the front end from the back end.
module bbum_jobq #(
    parameter int unsigned MAX_WIDTH = 1024,
    parameter int unsigned DEPTH     = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  bbum_pkg::t_job_ctl             i_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_addr,
    input  bbum_pkg::t_pixel               i_px,
    input  logic                           i_pop,
    output logic                           o_valid,
    output bbum_pkg::t_job_ctl             o_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_addr,
    output bbum_pkg::t_pixel               o_px,
    output logic                           o_full
);
    import bbum_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job_ctl      r_ctl  [DEPTH];
    logic [AW-1:0] r_addr [DEPTH];
    t_pixel        r_px   [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_ctl   = r_ctl[r_rd_ptr];
    assign o_addr  = r_addr[r_rd_ptr];
    assign o_px    = r_px[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ctl[r_wr_ptr]  <= i_ctl;
            r_addr[r_wr_ptr] <= i_addr;
            r_px[r_wr_ptr]   <= i_px;
        end
    end

endmodule

// ----- sv/bbum_back.sv -----
// Back end: line stores, 3x3 window, blur and boost pipeline, output register.
module bbum_back #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  bbum_pkg::t_job_ctl             i_q_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_q_addr,
    input  bbum_pkg::t_pixel               i_q_px,
    output logic                           o_q_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bbum_pkg::t_pixel               o_px,
    output logic                           o_last
);
    import bbum_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WIDTH);

    // Line stores: upper holds two rows back, middle one row back, per column.
    t_pixel r_line_upper  [MAX_WIDTH];
    t_pixel r_line_middle [MAX_WIDTH];
    t_pixel r_rd_up;
    t_pixel r_rd_md;

    // Stage 1: job plus store read data.
    logic          r_s1_valid;
    t_job_ctl      r_s1_ctl;
    logic [AW-1:0] r_s1_addr;
    t_pixel        r_s1_px;
    logic          r_s1_fwd;
    t_pixel        r_s1_fwd_up;
    t_pixel        r_s1_fwd_md;

    // Window: column C-1 (w1) and column C-2 (w2), rows top, middle, bottom.
    t_pixel r_w1_up, r_w1_md, r_w1_px;
    t_pixel r_w2_up, r_w2_md, r_w2_px;

    // Stage 2: neighborhood sums.
    logic             r_s2_valid;
    logic [SUM_W-1:0] r_s2_sum [NUM_LANES];
    t_pixel           r_s2_center;
    logic             r_s2_interior;
    logic             r_s2_last;

    // Stage 3: blurred values.
    logic                r_s3_valid;
    logic [SMOOTH_W-1:0] r_s3_smooth [NUM_LANES];
    t_pixel              r_s3_center;
    logic                r_s3_interior;
    logic                r_s3_last;

    // Output register.
    logic   r_o_valid;
    t_pixel r_o_px;
    logic   r_o_last;

    logic                advance;
    logic                wr_en;
    logic                fwd_hit;
    t_pixel              s1_up;
    t_pixel              s1_md;
    logic [SUM_W-1:0]    sum    [NUM_LANES];
    logic [PROD_W-1:0]   prod   [NUM_LANES];
    t_pixel              sharp_px;
    t_pixel              s1_center;
    logic                s1_keep;
    logic [LANE_W-1:0]   orig;
    logic [BOOST_W-1:0]  boost;

    always_comb begin
        advance = !(r_o_valid && i_out_stall);
        o_q_pop = advance && i_q_valid;
        wr_en   = advance && r_s1_valid && !r_s1_ctl.is_flush;
        s1_up   = r_s1_fwd ? r_s1_fwd_up : r_rd_up;
        s1_md   = r_s1_fwd ? r_s1_fwd_md : r_rd_md;
        // The job entering stage 1 reads the column the leaving job writes.
        fwd_hit = wr_en && (i_q_addr == r_s1_addr);
        s1_keep = r_s1_valid && (r_s1_ctl.is_flush || r_s1_ctl.emit);
        if (r_s1_ctl.is_flush) begin
            s1_center = r_s1_ctl.sel_mid ? s1_md : s1_up;
        end else begin
            s1_center = r_w1_md;
        end

        for (int k = 0; k < NUM_LANES; k++) begin
            sum[k] = (SUM_W'(lane_of(r_w2_up, k)) + SUM_W'(lane_of(r_w2_md, k))
                      + SUM_W'(lane_of(r_w2_px, k)))
                   + (SUM_W'(lane_of(r_w1_up, k)) + SUM_W'(lane_of(r_w1_md, k))
                      + SUM_W'(lane_of(r_w1_px, k)))
                   + (SUM_W'(lane_of(s1_up, k)) + SUM_W'(lane_of(s1_md, k))
                      + SUM_W'(lane_of(r_s1_px, k)));
            prod[k] = PROD_W'(r_s2_sum[k]) * PROD_W'(RECIP9);
        end

        sharp_px = '0;
        orig     = '0;
        boost    = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            orig  = lane_of(r_s3_center, k);
            boost = {1'b0, orig, 1'b0} - BOOST_W'(r_s3_smooth[k]);
            if (SMOOTH_W'(orig) > r_s3_smooth[k]) begin
                sharp_px[LANE_W*k +: LANE_W] =
                    (boost > BOOST_W'(LANE_MAX)) ? LANE_MAX : boost[LANE_W-1:0];
            end else begin
                sharp_px[LANE_W*k +: LANE_W] = orig;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line_upper[r_s1_addr]  <= s1_md;
            r_line_middle[r_s1_addr] <= r_s1_px;
        end
        if (o_q_pop) begin
            r_rd_up <= r_line_upper[i_q_addr];
            r_rd_md <= r_line_middle[i_q_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= i_q_valid;
            r_s2_valid <= s1_keep;
            r_s3_valid <= r_s2_valid;
            r_o_valid  <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_ctl    <= i_q_ctl;
            r_s1_addr   <= i_q_addr;
            r_s1_px     <= i_q_px;
            r_s1_fwd    <= fwd_hit;
            r_s1_fwd_up <= s1_md;
            r_s1_fwd_md <= r_s1_px;

            r_s2_center   <= s1_center;
            r_s2_interior <= !r_s1_ctl.is_flush && r_s1_ctl.interior;
            r_s2_last     <= r_s1_ctl.is_flush && r_s1_ctl.last;
            for (int k = 0; k < NUM_LANES; k++) begin
                r_s2_sum[k]    <= sum[k];
                r_s3_smooth[k] <= prod[k][PROD_W-1 -: SMOOTH_W];
            end

            r_s3_center   <= r_s2_center;
            r_s3_interior <= r_s2_interior;
            r_s3_last     <= r_s2_last;

            r_o_px   <= r_s3_interior ? sharp_px : r_s3_center;
            r_o_last <= r_s3_last;
        end
        if (wr_en) begin
            r_w2_up <= r_w1_up;
            r_w2_md <= r_w1_md;
            r_w2_px <= r_w1_px;
            r_w1_up <= s1_up;
            r_w1_md <= s1_md;
            r_w1_px <= r_s1_px;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_px        = r_o_px;
    assign o_last      = r_o_last;

endmodule

// ----- sv/box_blur_unsharp_mask_rgb.sv -----
// Top level of the streaming 3x3 box blur unsharp mask for RGB pixels.
//
//   channel  | handshake                       | payload
//   ---------+---------------------------------+-----------------------------------------
//   input    | i_in_valid / o_in_stall         | i_cmd, i_red_in, i_green_in, i_blue_in
//   output   | o_out_valid / i_out_stall       | o_red_out, o_green_out, o_blue_out,
//            |                                 | o_last_of_frame
//   config   | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// The block takes one beat per clock while o_in_stall is low and gives at most one result beat per clock.
// A result reaches the output register through the job queue, the store read, the sum,
// the reciprocal multiply and the boost and clamp, in that order.
// Reset is synchronous and active low; it sets the frame size to 640 by 480 and
// empties the queue and pipeline. The line stores need no clearing pass.
// A stall on a valid output freezes the whole back pipeline; the four-entry job queue
// then fills and raises o_in_stall.
module box_blur_unsharp_mask_rgb #(
    parameter int unsigned MAX_WIDTH = bbum_pkg::MAX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_cmd,
    input  logic [bbum_pkg::LANE_W-1:0]        i_red_in,
    input  logic [bbum_pkg::LANE_W-1:0]        i_green_in,
    input  logic [bbum_pkg::LANE_W-1:0]        i_blue_in,

    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [bbum_pkg::LANE_W-1:0]        o_red_out,
    output logic [bbum_pkg::LANE_W-1:0]        o_green_out,
    output logic [bbum_pkg::LANE_W-1:0]        o_blue_out,
    output logic                               o_last_of_frame,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bbum_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [bbum_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [bbum_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import bbum_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WIDTH);

    // Configuration registers, as written; the effective geometry is clamped below.
    logic [WIDTH_REG_W-1:0]  r_frame_width;
    logic [HEIGHT_REG_W-1:0] r_frame_height;

    logic             cfg_wr;
    t_reg_idx         reg_sel;
    logic [AW-1:0]    w_last;
    logic [ROW_W-1:0] h_last;

    logic             in_accept;
    t_pixel           in_px;

    logic             push;
    t_job_ctl         push_ctl;
    logic [AW-1:0]    push_addr;
    t_pixel           push_px;

    logic             q_valid;
    logic             q_full;
    logic             q_pop;
    t_job_ctl         q_ctl;
    logic [AW-1:0]    q_addr;
    t_pixel           q_px;

    t_pixel           out_px;

    // The port never waits. Only bit 2 of the address picks the register.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = t_reg_idx'(paddr[REG_SEL_BIT]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[WIDTH_REG_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // Last column and last row index of the frame. A zero size acts as one, and a size
    // beyond the store depth or the row limit is clamped to that limit.
    always_comb begin
        if (r_frame_width == '0) begin
            w_last = '0;
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_last = AW'(MAX_WIDTH - 1);
        end else begin
            w_last = AW'(r_frame_width - WIDTH_REG_W'(1));
        end

        if (r_frame_height == '0) begin
            h_last = '0;
        end else if (r_frame_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
            h_last = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            h_last = ROW_W'(r_frame_height - HEIGHT_REG_W'(1));
        end
    end

    // The front end takes a beat whenever the job queue has room.
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;
    assign in_px      = {i_blue_in, i_green_in, i_red_in};

    // A write to either register restarts the frame from its first pixel.
    bbum_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_wr),
        .i_w_last  (w_last),
        .i_h_last  (h_last),
        .i_accept  (in_accept),
        .i_cmd     (i_cmd),
        .i_px      (in_px),
        .o_push    (push),
        .o_ctl     (push_ctl),
        .o_addr    (push_addr),
        .o_px      (push_px)
    );

    bbum_jobq #(
        .MAX_WIDTH (MAX_WIDTH),
        .DEPTH     (JOBQ_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ctl   (push_ctl),
        .i_addr  (push_addr),
        .i_px    (push_px),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_ctl   (q_ctl),
        .o_addr  (q_addr),
        .o_px    (q_px),
        .o_full  (q_full)
    );

    // The back end owns the line stores and the window, so every store access and
    // window shift happens in job order there.
    bbum_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_ctl     (q_ctl),
        .i_q_addr    (q_addr),
        .i_q_px      (q_px),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_px        (out_px),
        .o_last      (o_last_of_frame)
    );

    assign o_red_out   = lane_of(out_px, 0);
    assign o_green_out = lane_of(out_px, 1);
    assign o_blue_out  = lane_of(out_px, 2);

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the streaming 3x3 box blur unsharp mask on RGB pixels.
`timescale 1ns / 1ps

module testbench;
    import bbum_pkg::*;

    // Run length guards. The nominal run is well under a tenth of the limit.
    localparam int unsigned CYCLE_LIMIT   = 2000000;
    localparam int unsigned RANDOM_PIXELS = 1000;
    // Settle time after the last owed pixel, enough to cover beats that are still
    // in flight without a result.
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned END_CYCLES    = 24;
    localparam int unsigned MAX_REPORTS   = 40;

    // One sharpened output pixel as the block presents it.
    typedef struct packed {
        logic [LANE_W-1:0] red;
        logic [LANE_W-1:0] green;
        logic [LANE_W-1:0] blue;
        logic              last;
    } t_sharp_pixel;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_cmd;
    logic [LANE_W-1:0]     i_red_in;
    logic [LANE_W-1:0]     i_green_in;
    logic [LANE_W-1:0]     i_blue_in;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [LANE_W-1:0]     o_red_out;
    logic [LANE_W-1:0]     o_green_out;
    logic [LANE_W-1:0]     o_blue_out;
    logic                  o_last_of_frame;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    box_blur_unsharp_mask_rgb u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_last_of_frame(o_last_of_frame),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the frame registers, line stores,
    // the two older window columns and the raster counters.
    // ------------------------------------------------------------------
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    t_pixel                  top_line [MAX_WIDTH_DEF];
    t_pixel                  mid_line [MAX_WIDTH_DEF];
    t_pixel                  near_col [3];   // column C-1: top, middle, bottom
    t_pixel                  far_col  [3];   // column C-2: top, middle, bottom
    int unsigned             col_ptr;
    int unsigned             row_ptr;
    int unsigned             out_idx;
    bit                      tail_open;

    // Sharpened pixels still owed by the block, oldest first.
    t_sharp_pixel            due_pixels[$];

    // Bookkeeping.
    int unsigned err_count;
    int unsigned checked_count;
    int unsigned pixel_beats;
    int unsigned flush_beats;
    int unsigned settings_count;
    int unsigned cycle_count;

    // Sender pacing and the receiver's long hold-off request.
    bit          paced;
    int unsigned burst_left;
    int unsigned hold_off_len;

    function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
            end
        end
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel px;
        for (int k = 0; k < NUM_LANES; k++) begin
            // Lean on the lane extremes so that both clamps get exercised.
            case ($urandom_range(0, 5))
                0: px[LANE_W*k +: LANE_W] = '0;
                1: px[LANE_W*k +: LANE_W] = '1;
                default: px[LANE_W*k +: LANE_W] = LANE_W'($urandom_range(0, 255));
            endcase
        end
        return px;
    endfunction

    // Clears the raster position, as any register write does in the block.
    function automatic void restart_frame();
        col_ptr   = 0;
        row_ptr   = 0;
        out_idx   = 0;
        tail_open = 1'b0;
    endfunction

    // Advances the predictor by one accepted beat and queues the pixel it yields.
    task automatic advance_sharpener(input t_cmd cmd, input t_pixel px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  q;
        int unsigned  col;
        int unsigned  orow;
        int unsigned  ocol;
        int unsigned  orig;
        int unsigned  smooth;
        int unsigned  boosted;
        logic [11:0]  lane_sum;
        t_pixel       up;
        t_pixel       md;
        t_pixel       res;
        t_pixel       nine [9];
        t_sharp_pixel beat;

        // Out-of-range sizes saturate to the legal range.
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
        h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;

        if (cmd == CMD_FLUSH) begin
            // A flush only does something while a finished frame still owes pixels.
            // The last row comes straight from the middle store; the one pixel
            // before it is the last column of the row above.
            if (tail_open) begin
                q = out_idx;
                res = (q / w + 1 >= h) ? mid_line[q % w] : top_line[w - 1];
                beat.red   = res[7:0];
                beat.green = res[15:8];
                beat.blue  = res[23:16];
                beat.last  = (q + 1 >= w * h);
                due_pixels.push_back(beat);
                out_idx = q + 1;
                if (beat.last) begin
                    out_idx   = 0;
                    tail_open = 1'b0;
                end
            end
        end else begin
            // Data arriving while a tail is pending abandons it and opens a new frame.
            if (tail_open) begin
                restart_frame();
            end
            col = col_ptr;
            up  = top_line[col];
            md  = mid_line[col];

            // Once one line plus one pixel is in, every pixel yields a result.
            if (row_ptr * w + col >= w + 1) begin
                q    = out_idx;
                orow = q / w;
                ocol = q % w;
                res  = near_col[1];
                if (orow >= 1 && orow + 1 < h && ocol >= 1 && ocol + 1 < w) begin
                    nine = '{far_col[0], far_col[1], far_col[2],
                             near_col[0], near_col[1], near_col[2], up, md, px};
                    for (int k = 0; k < NUM_LANES; k++) begin
                        lane_sum = '0;
                        for (int i = 0; i < 9; i++) begin
                            lane_sum = lane_sum + nine[i][LANE_W*k +: LANE_W];
                        end
                        orig    = near_col[1][LANE_W*k +: LANE_W];
                        smooth  = lane_sum / 9;
                        boosted = orig + ((orig > smooth) ? orig - smooth : 0);
                        if (boosted > 255) begin
                            boosted = 255;
                        end
                        res[LANE_W*k +: LANE_W] = LANE_W'(boosted);
                    end
                end
                beat.red   = res[7:0];
                beat.green = res[15:8];
                beat.blue  = res[23:16];
                beat.last  = 1'b0;
                due_pixels.push_back(beat);
                out_idx = q + 1;
            end

            top_line[col] = md;
            mid_line[col] = px;
            far_col       = near_col;
            near_col      = '{up, md, px};

            col++;
            if (col >= w) begin
                col = 0;
                row_ptr++;
                if (row_ptr >= h) begin
                    row_ptr   = 0;
                    tail_open = 1'b1;
                end
            end
            col_ptr = col;
        end
    endtask

    // ------------------------------------------------------------------
    // Sender. One call moves one beat. With pacing on, beats go out in bursts
    // of random length separated by random gaps; valid stays high across
    // consecutive beats of a burst and the payload holds while stalled.
    // ------------------------------------------------------------------
    task automatic send_beat(input t_cmd cmd, input t_pixel px);
        int unsigned gap;
        if (paced && burst_left == 0) begin
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 48 : 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_red_in   <= px[7:0];
        i_green_in <= px[15:8];
        i_blue_in  <= px[23:16];
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        advance_sharpener(cmd, px);
        if (cmd == CMD_FLUSH) begin
            flush_beats++;
        end else begin
            pixel_beats++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic stream_pixels(input int unsigned count);
        repeat (count) send_beat(CMD_PIXEL, rand_pixel());
    endtask

    // Flushes until the predictor says the frame's tail is fully drained.
    task automatic drain_tail();
        while (tail_open) send_beat(CMD_FLUSH, rand_pixel());
    endtask

    // Stops sending, waits for every owed pixel, then lets in-flight beats settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (due_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one frame register, with junk above the field, then reads it back.
    // The read setup follows the write access directly, so psel stays high.
    task automatic program_reg(input t_reg_idx idx, input int unsigned value);
        logic [31:0] mask;
        logic [31:0] word;
        mask = (idx == REG_FRAME_WIDTH) ? (32'd1 << WIDTH_REG_W) - 1
                                        : (32'd1 << HEIGHT_REG_W) - 1;
        word = ($urandom & ~mask) | (value & mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (idx == REG_FRAME_WIDTH) begin
            width_reg = word[WIDTH_REG_W-1:0];
        end else begin
            height_reg = word[HEIGHT_REG_W-1:0];
        end
        restart_frame();
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        compare_field("prdata", word & mask, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        settings_count++;
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // A hand-built 4x4 frame: saturating and zero-detail centers, a flush with
    // no tail pending, a partly drained tail cut off by new data, and a flush
    // that lands mid-frame.
    task automatic test_directed();
        t_pixel pattern [16];
        pattern = '{24'h000000, 24'hFFFFFF, 24'h00FF00, 24'hFF00FF,
                    24'h000000, 24'hFFFFFF, 24'h000000, 24'h123456,
                    24'hFFFFFF, 24'h000000, 24'h7F7F7F, 24'h0180FE,
                    24'hFFFFFF, 24'h00FF00, 24'h0000FF, 24'hFFFFFF};
        // Straight out of reset nothing is pending, so this flush is dropped.
        send_beat(CMD_FLUSH, 24'hFFFFFF);
        wait_idle();
        program_reg(REG_FRAME_WIDTH, 4);
        program_reg(REG_FRAME_HEIGHT, 4);
        foreach (pattern[i]) send_beat(CMD_PIXEL, pattern[i]);
        repeat (3) send_beat(CMD_FLUSH, 24'h000000);
        // Data during the tail starts the next frame; the flush after it is idle.
        send_beat(CMD_PIXEL, 24'hA5A5A5);
        send_beat(CMD_FLUSH, 24'h5A5A5A);
        wait_idle();
    endtask

    // Full frames at small sizes, including zero register values that act as one,
    // each followed by a flush with nothing left. Register values at or beyond the
    // limits are read back as written and then run for part of a frame.
    task automatic test_geometry_extremes();
        int unsigned widths  [8];
        int unsigned heights [8];
        int unsigned big_w   [4];
        int unsigned big_h   [4];
        widths  = '{1, 0, 2, 1, 3, 5, 1, 12};
        heights = '{1, 0, 1, 2, 3, 0, 4, 1};
        big_w   = '{2047, 1, 1024, 1500};
        big_h   = '{2, 8191, 4096, 5000};
        foreach (widths[i]) begin
            wait_idle();
            program_reg(REG_FRAME_WIDTH, widths[i]);
            program_reg(REG_FRAME_HEIGHT, heights[i]);
            stream_pixels(((widths[i] == 0) ? 1 : widths[i])
                        * ((heights[i] == 0) ? 1 : heights[i]));
            drain_tail();
            send_beat(CMD_FLUSH, rand_pixel());
        end
        foreach (big_w[i]) begin
            wait_idle();
            program_reg(REG_FRAME_WIDTH, big_w[i]);
            program_reg(REG_FRAME_HEIGHT, big_h[i]);
            stream_pixels(24);
        end
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while the sender keeps valid up,
    // so the job queue fills and the input stalls. Then the sender waits for
    // every owed pixel before it finishes the frame.
    task automatic test_backpressure();
        program_reg(REG_FRAME_WIDTH, 8);
        program_reg(REG_FRAME_HEIGHT, 30);
        stream_pixels(9);
        hold_off_len = 300;
        paced = 1'b0;
        stream_pixels(100);
        wait_idle();
        paced = 1'b1;
        stream_pixels(131);
        drain_tail();
        wait_idle();
    endtask

    // Mostly clean frames with random content at small sizes, mixed with
    // abandoned frames, stray flushes, cut-off tails and mid-frame pauses.
    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned cut;
        int unsigned start;
        start = pixel_beats;
        while (pixel_beats - start < RANDOM_PIXELS) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 10);
            n = w * h;
            wait_idle();
            program_reg(REG_FRAME_WIDTH, w);
            program_reg(REG_FRAME_HEIGHT, h);
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 9))
                    0: begin
                        // Abandon the frame part way; a register write restarts it.
                        stream_pixels($urandom_range(1, n));
                        wait_idle();
                        program_reg(REG_FRAME_HEIGHT, h);
                    end
                    1: begin
                        // Pause mid-frame until the block has caught up.
                        cut = $urandom_range(1, n);
                        stream_pixels(cut);
                        wait_idle();
                        stream_pixels(n - cut);
                        drain_tail();
                    end
                    2: begin
                        // Stray flushes sprinkled through the frame, extras after it.
                        repeat (n) begin
                            if ($urandom_range(0, 7) == 0) begin
                                send_beat(CMD_FLUSH, rand_pixel());
                            end
                            send_beat(CMD_PIXEL, rand_pixel());
                        end
                        drain_tail();
                        repeat (2) send_beat(CMD_FLUSH, rand_pixel());
                    end
                    3: begin
                        // Leave the tail partly drained; the next data cuts it off.
                        stream_pixels(n);
                        repeat ($urandom_range(0, w)) send_beat(CMD_FLUSH, rand_pixel());
                    end
                    default: begin
                        stream_pixels(n);
                        drain_tail();
                    end
                endcase
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Result checker: every beat taken from the output must match the oldest
    // owed pixel, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sharp_pixel want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (due_pixels.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS) begin
                    $display("%0t ns: result beat with nothing owed, expected none, %s %h %h %h %b",
                             $time, "actual", o_red_out, o_green_out, o_blue_out,
                             o_last_of_frame);
                end
            end else begin
                want = due_pixels.pop_front();
                compare_field("red_out", want.red, o_red_out);
                compare_field("green_out", want.green, o_green_out);
                compare_field("blue_out", want.blue, o_blue_out);
                compare_field("last_of_frame", want.last, o_last_of_frame);
                checked_count++;
            end
        end
    end

    // Receiver: the stall percentage is redrawn at random intervals, including
    // stretches with no stall at all. A long hold-off request overrides it and
    // is counted out here.
    initial begin
        int unsigned stall_pct;
        int unsigned mode_left;
        i_out_stall = 1'b0;
        stall_pct   = 0;
        mode_left   = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_off_len) @(posedge i_clk);
                hold_off_len = 0;
                i_out_stall <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(30, 200);
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 30;
                        default: stall_pct = 70;
                    endcase
                end
                mode_left--;
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Main sequence: reset, then each test in turn, then the verdict.
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_cmd        = CMD_PIXEL;
        i_red_in     = '0;
        i_green_in   = '0;
        i_blue_in    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        hold_off_len = 0;
        paced        = 1'b1;
        burst_left   = 0;
        err_count      = 0;
        checked_count  = 0;
        pixel_beats    = 0;
        flush_beats    = 0;
        settings_count = 0;

        // The predictor starts from the block's reset state.
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        foreach (top_line[i]) begin
            top_line[i] = '0;
            mid_line[i] = '0;
        end
        near_col = '{default: '0};
        far_col  = '{default: '0};
        restart_frame();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_geometry_extremes();
        test_backpressure();
        test_random_frames();

        wait_idle();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Sent %0d pixel beats and %0d flush beats across %0d register writes.",
                 pixel_beats, flush_beats, settings_count);
        $display("Checked %0d sharpened pixels; %0d mismatches, %0d still owed.",
                 checked_count, err_count, due_pixels.size());
        if (err_count == 0 && due_pixels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- box_blur_unsharp_mask_rgb.f -----
sv/bbum_pkg.sv
sv/bbum_front.sv
sv/bbum_jobq.sv
sv/bbum_back.sv
sv/box_blur_unsharp_mask_rgb.sv
sim/testbench.sv
